@@ rtl/core/tbo_pkg.sv @@
`timescale 1ns / 1ps
// Types and codes shared by the trigger box overlap table.
// No dependencies; imported by trigger_box_overlap_table_core.
package tbo_pkg;

  // Command codes carried on in_tuser.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Result status codes carried on out_tuser.
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_HIT     = 3'd1;
  localparam logic [2:0] ST_NONE    = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  // Configuration register indexes.
  localparam logic REG_TRIG_W = 1'b0;
  localparam logic REG_TRIG_H = 1'b1;

  localparam int CoordW = 16;
  localparam int SizeW  = 15;
  localparam int IdW    = 16;

  typedef struct packed {
    logic [IdW-1:0]           ident;
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic [SizeW-1:0]         wide;
    logic [SizeW-1:0]         tall;
  } slot_t;

endpackage

@@ rtl/core/trigger_box_overlap_table_core.sv @@
`timescale 1ns / 1ps
// Trigger box overlap table: object boxes held in one synchronous memory,
// scanned for remove and overlap query. Depends on tbo_pkg.
//
// Usage:
//   in_*   : one command beat. in_tuser is the command (add, remove, query),
//            in_tdata carries the id, the box and the trigger corner.
//   out_*  : result beats. out_tuser is the status, out_tdata the hit id,
//            out_tlast marks the final result of a command.
//   cfg_*  : writes trigger width (index 0) or height (index 1); always ready.
// Timing:
//   One command at a time. An add completes in S_ADD once the result register is free.
//   A remove or query walks slots 0 .. used-1 through the memory, one slot a
//   cycle unless stalled, with a registered read; a remove stops at its first
//   match. The read port sets this rate.
//   A query holds its latest hit back until the next hit or the end of the walk
//   so that tlast can be set on the final hit.
// Reset: all slots dead, fill count zero, trigger size zero; no clearing pass.
// Stall: the result register holds while out_tready is low and the slot walk
//   freezes (no new read) until the pending result can be placed.
module trigger_box_overlap_table_core #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // command channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // obj_id[15:0], box_x[31:16], box_y[47:32],
                                  // box_w[62:48], box_h[77:63], trigger_x[93:78],
                                  // trigger_y[109:94], zero pad[111:110]
  input  logic [1:0]   in_tuser,  // cmd[1:0]
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata, // hit_id[15:0]
  output logic [2:0]   out_tuser, // status[2:0]
  output logic         out_tlast,
  // configuration channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [14:0]  cfg_data
);
  import tbo_pkg::*;

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;

  // Latched command
  logic [1:0]              cmd_r, cmd_nxt;
  slot_t                   box_r, box_nxt;
  logic signed [CoordW-1:0] tx_r, tx_nxt;
  logic signed [CoordW-1:0] ty_r, ty_nxt;

  // Configuration
  logic [SizeW-1:0] trig_w_r, trig_w_nxt;
  logic [SizeW-1:0] trig_h_r, trig_h_nxt;

  // Table control
  logic [ENTRIES-1:0] live_r, live_nxt;
  logic [CNTW-1:0]    used_r, used_nxt;

  // Slot walk
  logic [CNTW-1:0] rd_idx_r, rd_idx_nxt;
  logic            ev_valid_r, ev_valid_nxt;
  logic [IDXW-1:0] ev_idx_r, ev_idx_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  logic [IdW-1:0]  pend_id_r, pend_id_nxt;

  // Result register
  logic           out_valid_r, out_valid_nxt;
  logic [2:0]     out_status_r, out_status_nxt;
  logic [IdW-1:0] out_id_r, out_id_nxt;
  logic           out_last_r, out_last_nxt;

  // Memory
  slot_t           slot_mem [ENTRIES];
  slot_t           rdata_r;
  logic            rd_en;
  logic            mem_wr;

  logic           in_fire;
  logic           out_free;
  logic           emit;
  logic [2:0]     emit_status;
  logic [IdW-1:0] emit_id;
  logic           emit_last;
  logic           stall;
  logic           rm_done;
  logic           issue;
  logic           hit;
  logic           match;

  logic signed [CoordW+1:0] s_left, s_right, s_top, s_bottom;
  logic signed [CoordW+1:0] t_left, t_right, t_top, t_bottom;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // Strict overlap of the slot under evaluation with the trigger rectangle.
  always_comb begin
    s_left   = {{2{rdata_r.left[CoordW-1]}}, rdata_r.left};
    s_top    = {{2{rdata_r.top[CoordW-1]}}, rdata_r.top};
    s_right  = s_left + $signed({3'b000, rdata_r.wide});
    s_bottom = s_top + $signed({3'b000, rdata_r.tall});
    t_left   = {{2{tx_r[CoordW-1]}}, tx_r};
    t_top    = {{2{ty_r[CoordW-1]}}, ty_r};
    t_right  = t_left + $signed({3'b000, trig_w_r});
    t_bottom = t_top + $signed({3'b000, trig_h_r});
  end

  assign hit   = live_r[ev_idx_r] && (t_left < s_right) && (t_right > s_left) &&
                 (t_top < s_bottom) && (t_bottom > s_top);
  assign match = live_r[ev_idx_r] && (rdata_r.ident == box_r.ident);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    box_nxt        = box_r;
    tx_nxt         = tx_r;
    ty_nxt         = ty_r;
    trig_w_nxt     = trig_w_r;
    trig_h_nxt     = trig_h_r;
    live_nxt       = live_r;
    used_nxt       = used_r;
    rd_idx_nxt     = rd_idx_r;
    ev_valid_nxt   = ev_valid_r;
    ev_idx_nxt     = ev_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    emit           = 1'b0;
    emit_status    = ST_DONE;
    emit_id        = '0;
    emit_last      = 1'b1;
    stall          = 1'b0;
    rm_done        = 1'b0;
    issue          = 1'b0;
    rd_en          = 1'b0;
    mem_wr         = 1'b0;

    if (cfg_valid) begin
      if (cfg_index == REG_TRIG_W) begin
        trig_w_nxt = cfg_data;
      end else begin
        trig_h_nxt = cfg_data;
      end
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = in_tuser;
          box_nxt.ident  = in_tdata[15:0];
          box_nxt.left   = in_tdata[31:16];
          box_nxt.top    = in_tdata[47:32];
          box_nxt.wide   = in_tdata[62:48];
          box_nxt.tall   = in_tdata[77:63];
          tx_nxt         = in_tdata[93:78];
          ty_nxt         = in_tdata[109:94];
          rd_idx_nxt     = '0;
          ev_valid_nxt   = 1'b0;
          pend_valid_nxt = 1'b0;
          case (in_tuser)
            CMD_ADD:    state_nxt = S_ADD;
            CMD_REMOVE: state_nxt = S_SCAN;
            CMD_QUERY:  state_nxt = S_SCAN;
            default:    state_nxt = S_IDLE;  // unused code: drop silently
          endcase
        end
      end

      S_ADD: begin
        if (out_free) begin
          emit = 1'b1;
          if (used_r == CNTW'(ENTRIES)) begin
            emit_status = ST_FULL;
          end else begin
            emit_status                 = ST_DONE;
            mem_wr                      = 1'b1;
            live_nxt[used_r[IDXW-1:0]]  = 1'b1;
            used_nxt                    = used_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        // Evaluate the slot held in the read register.
        if (ev_valid_r) begin
          if (cmd_r == CMD_QUERY) begin
            if (hit) begin
              if (pend_valid_r) begin
                if (out_free) begin
                  emit        = 1'b1;
                  emit_status = ST_HIT;
                  emit_id     = pend_id_r;
                  emit_last   = 1'b0;
                  pend_id_nxt = rdata_r.ident;
                end else begin
                  stall = 1'b1;
                end
              end else begin
                pend_valid_nxt = 1'b1;
                pend_id_nxt    = rdata_r.ident;
              end
            end
          end else if (match) begin
            if (out_free) begin
              emit               = 1'b1;
              emit_status        = ST_DONE;
              live_nxt[ev_idx_r] = 1'b0;
              ev_valid_nxt       = 1'b0;
              state_nxt          = S_IDLE;
              rm_done            = 1'b1;
            end else begin
              stall = 1'b1;
            end
          end
        end

        // Advance the walk: issue the next read or close out the command.
        if (!stall && !rm_done) begin
          issue        = (rd_idx_r < used_r);
          rd_en        = issue;
          ev_valid_nxt = issue;
          ev_idx_nxt   = rd_idx_r[IDXW-1:0];
          if (issue) begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
          if (!ev_valid_r && !issue && out_free) begin
            emit = 1'b1;
            if (cmd_r == CMD_QUERY) begin
              if (pend_valid_r) begin
                emit_status = ST_HIT;
                emit_id     = pend_id_r;
              end else begin
                emit_status = ST_NONE;
              end
            end else begin
              emit_status = ST_MISSING;
            end
            pend_valid_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = emit_status;
      out_id_nxt     = emit_id;
      out_last_nxt   = emit_last;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      trig_w_r     <= '0;
      trig_h_r     <= '0;
      live_r       <= '0;
      used_r       <= '0;
      ev_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      trig_w_r     <= trig_w_nxt;
      trig_h_r     <= trig_h_nxt;
      live_r       <= live_nxt;
      used_r       <= used_nxt;
      ev_valid_r   <= ev_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    box_r        <= box_nxt;
    tx_r         <= tx_nxt;
    ty_r         <= ty_nxt;
    rd_idx_r     <= rd_idx_nxt;
    ev_idx_r     <= ev_idx_nxt;
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      slot_mem[used_r[IDXW-1:0]] <= box_r;
    end
    if (rd_en) begin
      rdata_r <= slot_mem[rd_idx_r[IDXW-1:0]];
    end
  end

  // Checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNTW'(ENTRIES))
    else $error("fill count beyond table depth");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid_r |-> (state_r == S_SCAN))
    else $error("slot evaluation outside a walk");

  a_pend_query: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == S_SCAN) && (cmd_r == CMD_QUERY))
    else $error("held hit outside a query walk");

  a_nonlast_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == ST_HIT))
    else $error("non-final result that is not a hit");

  a_used_grows_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && out_free && used_r != CNTW'(ENTRIES)) |=>
      (used_r == $past(used_r) + 1'b1))
    else $error("add did not advance the fill count");

endmodule
